>>> rtl/nps_pkg.sv
// Package for the nearest point search unit: field widths, opcodes,
// register map, controller states and the lane control struct.
// No dependencies; every other file of the block imports it.
`default_nettype none

package nps_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIMS      = 4;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned DSQ_W     = 34;
  localparam int unsigned ROOT_W    = 17;
  localparam int unsigned IDX_OUT_W = 8;
  localparam int unsigned DIMS_W    = 3;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(DIMS);

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_DIMS_USED = 3'd0;

  // Cycles a lane needs after its last read before its best entry is final,
  // beyond the read cycle itself.
  localparam int unsigned DRAIN_CYCLES = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } nps_op_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_MERGE  = 6'b001000,
    ST_SQRT   = 6'b010000,
    ST_RESULT = 6'b100000
  } nps_state_e;

  typedef logic [DIMS-1:0][COORD_W-1:0] nps_point_t;

  typedef struct packed {
    logic start;   // clear the lane's running best
    logic wr_en;   // store the load point in this lane
    logic rd_en;   // read one row for the search
    logic rd_vld;  // the row read holds a stored point
  } nps_lane_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/nps_in_if.sv
// Input channel of the nearest point search unit: opcode and one point.
// Depends on nps_pkg.
`default_nettype none

interface nps_in_if;
  logic                                valid;
  logic                                ready;
  logic [nps_pkg::OP_W-1:0]            op;
  logic signed [nps_pkg::COORD_W-1:0]  coord_0;
  logic signed [nps_pkg::COORD_W-1:0]  coord_1;
  logic signed [nps_pkg::COORD_W-1:0]  coord_2;
  logic signed [nps_pkg::COORD_W-1:0]  coord_3;

  modport source (output valid, op, coord_0, coord_1, coord_2, coord_3, input ready);
  modport sink   (input valid, op, coord_0, coord_1, coord_2, coord_3, output ready);
endinterface

`default_nettype wire

>>> rtl/nps_out_if.sv
// Result channel of the nearest point search unit.
// Depends on nps_pkg.
`default_nettype none

interface nps_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [nps_pkg::IDX_OUT_W-1:0]      nearest_index;
  logic [nps_pkg::DSQ_W-1:0]          dist_squared;
  logic [nps_pkg::ROOT_W-1:0]         distance;

  modport source (output valid, found, nearest_index, dist_squared, distance, input ready);
  modport sink   (input valid, found, nearest_index, dist_squared, distance, output ready);
endinterface

`default_nettype wire

>>> rtl/nps_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on nps_pkg.
`default_nettype none

module nps_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [nps_pkg::DSQ_W-1:0]   value_i,
  output logic                             done_o,
  output logic [nps_pkg::ROOT_W-1:0]       root_o
);
  import nps_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DSQ_W-1:0] val_q, val_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0] rem_sh, trial;

  // Remainder with the next two radicand bits, against 4*root + 1.
  assign rem_sh = {rem_q[ROOT_W:0], val_q[DSQ_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ROOT_W);
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        val_d = {val_q[DSQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> rtl/nps_lane.sv
// One search lane: a bank of the reference store, a distance pipeline
// and the lane's running best. Depends on nps_pkg.
`default_nettype none

module nps_lane #(
  parameter int unsigned LANE_ID = 0,
  parameter int unsigned ROWS    = 64,
  parameter int unsigned IDX_W   = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire nps_pkg::nps_lane_ctrl_t                ctrl_i,
  input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_addr_i,
  input  wire nps_pkg::nps_point_t                    wr_pt_i,
  input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_addr_i,
  input  wire logic [IDX_W-1:0]                       rd_base_i,
  input  wire nps_pkg::nps_point_t                    qry_pt_i,
  input  wire logic [nps_pkg::DIMS-1:0]               dim_mask_i,
  output logic                                        best_vld_o,
  output logic [nps_pkg::DSQ_W-1:0]                   best_dist_o,
  output logic [IDX_W-1:0]                            best_idx_o
);
  import nps_pkg::*;

  nps_point_t mem [ROWS];

  nps_point_t                   rd_data_q;
  logic                         rd_vld_q, sq_vld_q, sum_vld_q;
  logic [IDX_W-1:0]             rd_idx_q, sq_idx_q, sum_idx_q;
  logic [DIMS-1:0][DSQ_W-1:0]   sq_d, sq_q;
  logic [DSQ_W-1:0]             sum_d, sum_q;
  logic                         best_vld_q;
  logic [DSQ_W-1:0]             best_dist_q;
  logic [IDX_W-1:0]             best_idx_q;
  logic                         take;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_pt_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
      rd_idx_q  <= rd_base_i + IDX_W'(LANE_ID);
    end
  end

  // One multiplier per dimension; unused dimensions contribute zero.
  // The square is taken on the magnitude, which always fits in COORD_W bits.
  always_comb begin
    logic signed [COORD_W:0]  diff;
    logic [COORD_W-1:0]       mag;
    logic [2*COORD_W-1:0]     mag_w;
    for (int d = 0; d < DIMS; d++) begin
      diff = $signed({qry_pt_i[d][COORD_W-1], qry_pt_i[d]})
           - $signed({rd_data_q[d][COORD_W-1], rd_data_q[d]});
      mag     = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
      mag_w   = (2*COORD_W)'(mag);
      sq_d[d] = dim_mask_i[d] ? DSQ_W'(mag_w * mag_w) : '0;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int d = 0; d < DIMS; d++) begin
      sum_d = sum_d + sq_q[d];
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_d;
    sq_idx_q  <= rd_idx_q;
    sum_q     <= sum_d;
    sum_idx_q <= sq_idx_q;
  end

  // Rows arrive in ascending index order, so a strict compare keeps the first.
  assign take = sum_vld_q && (!best_vld_q || (sum_q < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      sq_vld_q   <= 1'b0;
      sum_vld_q  <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= ctrl_i.rd_en && ctrl_i.rd_vld;
      sq_vld_q  <= rd_vld_q;
      sum_vld_q <= sq_vld_q;
      if (ctrl_i.start) begin
        best_vld_q <= 1'b0;
      end else if (take) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dist_q <= sum_q;
      best_idx_q  <= sum_idx_q;
    end
  end

  assign best_vld_o  = best_vld_q;
  assign best_dist_o = best_dist_q;
  assign best_idx_o  = best_idx_q;

endmodule

`default_nettype wire

>>> rtl/nearest_point_search_unit.sv
// Nearest point search unit: controller, lane array, lane merge, square
// root and result register. Depends on nps_pkg, nps_in_if, nps_out_if,
// nps_lane and nps_isqrt.
//
//   channel   direction  transaction
//   in_ch     sink       op with one point (load, query or clear)
//   out_ch    source     one result per query
//   apb       slave      dims_used register at byte address 0
//
// Load, clear and unused ops complete in the cycle they are accepted.
// A query on a non-empty store goes through the lane scan, which reads
// one row per lane each cycle, then the drain, one merge step per lane,
// the square root and the result state. A query on an empty store goes
// straight to the result state. The result register lets the next
// transaction be accepted while a result waits; a query finishing while
// the register is still full waits for it. Reset empties the store, no
// sweep.
`default_nettype none

module nearest_point_search_unit #(
  parameter int unsigned REF_POINTS = 256,
  parameter int unsigned LANES      = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  nps_in_if.sink                             in_ch,
  nps_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [nps_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [nps_pkg::PDATA_W-1:0]   pwdata,
  output logic [nps_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import nps_pkg::*;

  localparam int unsigned ROWS   = (REF_POINTS + LANES - 1) / LANES;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned WA_W   = $clog2(ROWS + 1);
  localparam int unsigned LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned CNT_W  = $clog2(REF_POINTS + 1);
  localparam int unsigned IDX_W  = (REF_POINTS > 1) ? $clog2(REF_POINTS) : 1;
  localparam int unsigned DRN_W  = $clog2(DRAIN_CYCLES + 1);

  nps_state_e        state_q, state_d;
  logic [DIMS_W-1:0] dims_q;
  logic [DIMS-1:0]   dim_mask_q, dim_mask_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [WA_W-1:0]   wr_addr_q;
  logic [LANE_W-1:0] wr_lane_q;
  logic [WA_W-1:0]   rd_addr_q, nrows;
  logic [IDX_W-1:0]  rd_base_q;
  logic [DRN_W-1:0]  drn_q;
  logic [LANE_W-1:0] mrg_q;
  nps_point_t        qry_q, in_pt;

  logic              mrg_vld_q, mrg_vld_d;
  logic [DSQ_W-1:0]  mrg_dist_q, mrg_dist_d;
  logic [IDX_W-1:0]  mrg_idx_q, mrg_idx_d;
  logic [31:0]       mrg_idx_ext;

  logic                  out_valid_q, out_found_q;
  logic [IDX_OUT_W-1:0]  out_idx_q;
  logic [DSQ_W-1:0]      out_dsq_q;
  logic [ROOT_W-1:0]     out_dist_q;

  logic in_acc, do_load, do_query, do_clear, cfg_wr, store_full;
  logic scan_last, drain_last, merge_last, out_free;
  logic sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;

  nps_lane_ctrl_t     lane_ctrl [LANES];
  logic               lane_vld  [LANES];
  logic [DSQ_W-1:0]   lane_dist [LANES];
  logic [IDX_W-1:0]   lane_idx  [LANES];
  logic               cand_take;

  // ---------------------------------------------------------------- config
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_DIMS_USED);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_DIMS_USED) ? PDATA_W'(dims_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_RESET;
    end else if (cfg_wr) begin
      dims_q <= pwdata[DIMS_W-1:0];
    end
  end

  // Zero behaves as one dimension, values past DIMS as all of them.
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      dim_mask_d[d] = (d == 0) || (DIMS_W'(d) < dims_q);
    end
  end

  always_ff @(posedge clk_i) begin
    dim_mask_q <= dim_mask_d;
  end

  // ---------------------------------------------------------------- input
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign do_load     = in_acc && (in_ch.op == OP_LOAD);
  assign do_query    = in_acc && (in_ch.op == OP_QUERY);
  assign do_clear    = in_acc && (in_ch.op == OP_CLEAR);
  assign store_full  = (cnt_q == CNT_W'(REF_POINTS));

  assign in_pt[0] = in_ch.coord_0;
  assign in_pt[1] = in_ch.coord_1;
  assign in_pt[2] = in_ch.coord_2;
  assign in_pt[3] = in_ch.coord_3;

  always_ff @(posedge clk_i) begin
    if (do_query) begin
      qry_q <= in_pt;
    end
  end

  // Stored points are dealt round-robin over the lanes, one row per round.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      wr_addr_q <= '0;
      wr_lane_q <= '0;
    end else if (do_clear) begin
      cnt_q     <= '0;
      wr_addr_q <= '0;
      wr_lane_q <= '0;
    end else if (do_load && !store_full) begin
      cnt_q <= cnt_q + 1'b1;
      if (wr_lane_q == LANE_W'(LANES - 1)) begin
        wr_lane_q <= '0;
        wr_addr_q <= wr_addr_q + 1'b1;
      end else begin
        wr_lane_q <= wr_lane_q + 1'b1;
      end
    end
  end

  assign nrows = wr_addr_q + WA_W'(wr_lane_q != '0);

  // ---------------------------------------------------------------- control
  assign scan_last  = (rd_addr_q == nrows - 1'b1);
  assign drain_last = (drn_q == DRN_W'(DRAIN_CYCLES - 1));
  assign merge_last = (mrg_q == LANE_W'(LANES - 1));
  assign out_free   = !out_valid_q || out_ch.ready;
  assign sq_start   = (state_q == ST_MERGE) && merge_last;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_query) begin
          state_d = (cnt_q == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_last) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (merge_last) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_addr_q <= '0;
      rd_base_q <= '0;
      drn_q     <= '0;
      mrg_q     <= '0;
    end else begin
      state_q <= state_d;
      if (do_query) begin
        rd_addr_q <= '0;
        rd_base_q <= '0;
      end else if (state_q == ST_SCAN) begin
        rd_addr_q <= rd_addr_q + 1'b1;
        rd_base_q <= rd_base_q + IDX_W'(LANES);
      end
      drn_q <= (state_q == ST_DRAIN) ? drn_q + 1'b1 : '0;
      mrg_q <= (state_q == ST_MERGE) ? mrg_q + 1'b1 : '0;
    end
  end

  // ---------------------------------------------------------------- lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    always_comb begin
      lane_ctrl[l].start  = do_query;
      lane_ctrl[l].wr_en  = do_load && !store_full && (wr_lane_q == LANE_W'(l));
      lane_ctrl[l].rd_en  = (state_q == ST_SCAN);
      lane_ctrl[l].rd_vld = (rd_addr_q < wr_addr_q)
                         || ((rd_addr_q == wr_addr_q) && (LANE_W'(l) < wr_lane_q));
    end

    nps_lane #(
      .LANE_ID (l),
      .ROWS    (ROWS),
      .IDX_W   (IDX_W)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (lane_ctrl[l]),
      .wr_addr_i   (wr_addr_q[ROW_W-1:0]),
      .wr_pt_i     (in_pt),
      .rd_addr_i   (rd_addr_q[ROW_W-1:0]),
      .rd_base_i   (rd_base_q),
      .qry_pt_i    (qry_q),
      .dim_mask_i  (dim_mask_q),
      .best_vld_o  (lane_vld[l]),
      .best_dist_o (lane_dist[l]),
      .best_idx_o  (lane_idx[l])
    );
  end

  // ---------------------------------------------------------------- merge
  // Lanes interleave indexes, so equal distances fall back to the index.
  assign cand_take = lane_vld[mrg_q]
                  && (!mrg_vld_q
                      || (lane_dist[mrg_q] < mrg_dist_q)
                      || ((lane_dist[mrg_q] == mrg_dist_q) && (lane_idx[mrg_q] < mrg_idx_q)));

  always_comb begin
    mrg_vld_d  = mrg_vld_q;
    mrg_dist_d = mrg_dist_q;
    mrg_idx_d  = mrg_idx_q;
    if (do_query) begin
      mrg_vld_d  = 1'b0;
      mrg_dist_d = '0;
      mrg_idx_d  = '0;
    end else if ((state_q == ST_MERGE) && cand_take) begin
      mrg_vld_d  = 1'b1;
      mrg_dist_d = lane_dist[mrg_q];
      mrg_idx_d  = lane_idx[mrg_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mrg_vld_q <= 1'b0;
    end else begin
      mrg_vld_q <= mrg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mrg_dist_q <= mrg_dist_d;
    mrg_idx_q  <= mrg_idx_d;
  end

  nps_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (mrg_dist_d),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // ---------------------------------------------------------------- result
  assign mrg_idx_ext = 32'(mrg_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_RESULT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESULT) && out_free) begin
      out_found_q <= mrg_vld_q;
      out_idx_q   <= mrg_idx_ext[IDX_OUT_W-1:0];
      out_dsq_q   <= mrg_dist_q;
      out_dist_q  <= mrg_vld_q ? sq_root : '0;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.found         = out_found_q;
  assign out_ch.nearest_index = out_idx_q;
  assign out_ch.dist_squared  = out_dsq_q;
  assign out_ch.distance      = out_dist_q;

endmodule

`default_nettype wire

>>> rtl/nps_checker.sv
// Port-level checker for nearest_point_search_unit, bound to the top level.
// Depends on nps_pkg and the top level's ports.
`default_nettype none

module nps_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [nps_pkg::OP_W-1:0]          in_op,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_found,
  input wire logic [nps_pkg::IDX_OUT_W-1:0]     out_index,
  input wire logic [nps_pkg::DSQ_W-1:0]         out_dsq,
  input wire logic [nps_pkg::ROOT_W-1:0]        out_dist
);
  import nps_pkg::*;

  // A waiting result keeps its squared distance and index until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_dsq) && $stable(out_index))
    else $error("result changed while stalled");

  // A query keeps the input closed while the search runs.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_op == OP_QUERY) |=> !in_ready)
    else $error("input accepted during a search");

  // A new result only appears at the end of a search.
  a_result_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a search");

  // An empty store reports all zeros.
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_found |-> (out_index == '0) && (out_dsq == '0) && (out_dist == '0))
    else $error("not-found result carries data");

  // The distance is the floor square root of the squared distance.
  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ((36'(out_dist) * 36'(out_dist)) <= 36'(out_dsq))
               && (((36'(out_dist) + 36'd1) * (36'(out_dist) + 36'd1)) > 36'(out_dsq)))
    else $error("distance is not the floor square root");

endmodule

bind nearest_point_search_unit nps_checker u_nps_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_found (out_ch.found),
  .out_index (out_ch.nearest_index),
  .out_dsq   (out_ch.dist_squared),
  .out_dist  (out_ch.distance)
);

`default_nettype wire

>>> tb/nps_checker.sv
// Scoreboard for the nearest point search unit: watches the input and result
// channels and the APB register writes, predicts each query and compares.
// Depends on nps_pkg, nps_in_if and nps_out_if.

module nps_scoreboard #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  nps_in_if                                in_mon,
  nps_out_if                               out_mon,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic                        pready,
  input  wire logic [nps_pkg::PADDR_W-1:0] paddr,
  input  wire logic [nps_pkg::PDATA_W-1:0] pwdata,
  output int                               fail_count,
  output int                               awaited_count
);
  import nps_pkg::*;

  typedef struct packed {
    logic                 found;
    logic [IDX_OUT_W-1:0] index;
    logic [DSQ_W-1:0]     dsq;
    logic [ROOT_W-1:0]    root;
  } nearest_t;

  localparam longint unsigned DSQ_CEIL = (64'd1 << DSQ_W) - 64'd1;

  nps_point_t        ref_pts [STORE_DEPTH];
  int unsigned       ref_fill;
  logic [DIMS_W-1:0] dims_reg;
  nearest_t          awaited_nearest [$];

  function automatic logic [ROOT_W-1:0] floor_root(input logic [DSQ_W-1:0] v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[ROOT_W-1:0];
  endfunction

  // Linear scan over the stored points; only a strictly smaller sum replaces
  // the current best, so the lowest index wins a tie.
  function automatic nearest_t nearest_to(input nps_point_t q);
    nearest_t        res;
    longint unsigned sum;
    longint unsigned best;
    longint          diff;
    int unsigned     nd;
    res  = '0;
    best = 0;
    if (ref_fill == 0) return res;
    nd = (dims_reg == 0) ? 1 : ((dims_reg > DIMS) ? DIMS : dims_reg);
    for (int unsigned n = 0; n < ref_fill; n++) begin
      sum = 0;
      for (int unsigned d = 0; d < nd; d++) begin
        diff = longint'($signed(q[d])) - longint'($signed(ref_pts[n][d]));
        sum += diff * diff;
      end
      if (sum > DSQ_CEIL) sum = DSQ_CEIL;
      if (n == 0 || sum < best) begin
        best      = sum;
        res.index = IDX_OUT_W'(n);
      end
    end
    res.found = 1'b1;
    res.dsq   = best[DSQ_W-1:0];
    res.root  = floor_root(res.dsq);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nps_point_t pt;
    nearest_t   want;
    if (!rst_ni) begin
      ref_fill   = 0;
      dims_reg   = DIMS_RESET;
      fail_count = 0;
      awaited_nearest.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_nearest.size() == 0) begin
          $display("%0t: result with no query pending, expected none, actual index %0d",
                   $time, out_mon.nearest_index);
          fail_count++;
        end else begin
          want = awaited_nearest.pop_front();
          check_field("found", 64'(want.found), 64'(out_mon.found));
          check_field("nearest_index", 64'(want.index), 64'(out_mon.nearest_index));
          check_field("dist_squared", 64'(want.dsq), 64'(out_mon.dist_squared));
          check_field("distance", 64'(want.root), 64'(out_mon.distance));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pt = {in_mon.coord_3, in_mon.coord_2, in_mon.coord_1, in_mon.coord_0};
        case (in_mon.op)
          OP_LOAD: begin
            // A full store ignores further loads.
            if (ref_fill < STORE_DEPTH) begin
              ref_pts[ref_fill] = pt;
              ref_fill++;
            end
          end
          OP_QUERY: awaited_nearest.push_back(nearest_to(pt));
          OP_CLEAR: ref_fill = 0;
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready && paddr == REG_DIMS_USED) begin
        dims_reg = pwdata[DIMS_W-1:0];
      end
    end
    awaited_count = awaited_nearest.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the nearest point search unit testbench: clock, reset, stimulus on
// the input channel and APB port, result back-pressure and the verdict.
// Depends on nps_pkg, nps_in_if, nps_out_if, nps_checker and the block.

module testbench;
  import nps_pkg::*;

  localparam int unsigned      STORE_DEPTH   = 256;
  localparam logic [OP_W-1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned      SETTLE_CYCLES = 120;
  localparam int unsigned      RANDOM_ITEMS  = 1250;
  localparam longint unsigned  RUN_LIMIT     = 3000000;
  localparam logic [DIMS_W-1:0] DIMS_SWEEP [6] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5};

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 awaited_count;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  nps_point_t  stored_copy [STORE_DEPTH];
  int unsigned stored_n = 0;
  int unsigned n_loads = 0;
  int unsigned n_queries = 0;
  int unsigned n_clears = 0;
  int unsigned n_unused = 0;
  int unsigned n_writes = 0;
  int unsigned n_items = 0;

  nps_in_if  in_ch ();
  nps_out_if out_ch ();

  nearest_point_search_unit #(.REF_POINTS(STORE_DEPTH)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nps_scoreboard #(.STORE_DEPTH(STORE_DEPTH)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #RUN_LIMIT;
    $display("[nearest_point_search_unit] ERROR");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return COORD_W'($urandom_range(16)) - 16'd8;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic nps_point_t rand_point();
    nps_point_t p;
    for (int d = 0; d < DIMS; d++) p[d] = rand_coord();
    return p;
  endfunction

  // Queries mostly land on or near a stored point so that small distances
  // and exact ties show up, not only wide random spreads.
  function automatic nps_point_t query_point();
    nps_point_t  p;
    int unsigned r;
    r = $urandom_range(99);
    if (stored_n == 0 || r >= 70) return rand_point();
    p = stored_copy[$urandom_range(stored_n - 1)];
    if (r >= 20) begin
      for (int d = 0; d < DIMS; d++) p[d] = p[d] + COORD_W'($urandom_range(6)) - 16'd3;
    end
    return p;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input nps_point_t pt);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.coord_0 <= pt[0];
    in_ch.coord_1 <= pt[1];
    in_ch.coord_2 <= pt[2];
    in_ch.coord_3 <= pt[3];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    case (op)
      OP_LOAD: begin
        if (stored_n < STORE_DEPTH) begin
          stored_copy[stored_n] = pt;
          stored_n++;
          n_loads++;
          n_items++;
        end
      end
      OP_QUERY: begin
        n_queries++;
        n_items++;
      end
      OP_CLEAR: begin
        stored_n = 0;
        n_clears++;
        n_items++;
      end
      default: n_unused++;
    endcase
  endtask

  // Holds the sender back until every query has been answered, then lets
  // the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_dims(input logic [DIMS_W-1:0] v);
    wait_idle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DIMS_USED;
    pwdata  <= PDATA_W'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
  endtask

  task automatic run_batch(input int unsigned n_pts, input int unsigned n_ask);
    send_item(OP_CLEAR, rand_point());
    for (int unsigned i = 0; i < n_pts; i++) begin
      if ($urandom_range(7) == 0 && stored_n != 0) begin
        send_item(OP_LOAD, stored_copy[$urandom_range(stored_n - 1)]);
      end else begin
        send_item(OP_LOAD, rand_point());
      end
    end
    for (int unsigned i = 0; i < n_ask; i++) send_item(OP_QUERY, query_point());
  endtask

  initial begin
    int unsigned base;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_LOAD;
    in_ch.coord_0 = '0;
    in_ch.coord_1 = '0;
    in_ch.coord_2 = '0;
    in_ch.coord_3 = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(OP_QUERY, '0);
    send_item(OP_UNUSED, '1);
    send_item(OP_LOAD, {4{16'h8000}});
    send_item(OP_LOAD, {4{16'h7fff}});
    send_item(OP_LOAD, '0);
    send_item(OP_LOAD, {4{16'h7fff}});
    send_item(OP_QUERY, {4{16'h7fff}});
    send_item(OP_QUERY, {4{16'h8000}});
    send_item(OP_QUERY, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    for (int i = 0; i < 6; i++) begin
      write_dims(DIMS_SWEEP[i]);
      send_item(OP_QUERY, {16'h0005, 16'hfffb, 16'h7fff, 16'h8000});
    end
    write_dims(DIMS_RESET);
    send_item(OP_QUERY, {16'h0005, 16'hfffb, 16'h7fff, 16'h8000});
    // The largest possible distance: opposite corners in all four dimensions.
    send_item(OP_CLEAR, '1);
    send_item(OP_LOAD, {4{16'h7fff}});
    send_item(OP_QUERY, {4{16'h8000}});
    send_item(OP_CLEAR, '0);
    send_item(OP_QUERY, {4{16'h8000}});
    send_item(OP_UNUSED, '0);

    base = n_items;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 15 : ((ph == 1) ? 68 : 0);
      recv_idle = (ph == 0) ? 68 : ((ph == 1) ? 15 : 0);
      // Fill the store past its capacity once; the extra loads are dropped.
      if (ph == 2) run_batch(STORE_DEPTH + 3, 10);
      while (n_items < base + (ph + 1) * RANDOM_ITEMS / 3) begin
        case ($urandom_range(19))
          0, 1, 2: write_dims(DIMS_W'($urandom_range(7)));
          3: wait_idle();
          default: ;
        endcase
        if ($urandom_range(99) < 80) begin
          run_batch($urandom_range(1, 24), $urandom_range(1, 8));
        end else begin
          repeat ($urandom_range(1, 4)) send_item(OP_W'($urandom_range(3)), rand_point());
        end
      end
    end

    wait_idle();
    $display("Sent %0d queries, %0d stored loads, %0d clears, %0d unused ops; %0d dims_used writes,",
             n_queries, n_loads, n_clears, n_unused, n_writes);
    $display("with the store filled past capacity and three sender/receiver stall mixes.");
    if (fail_count == 0 && awaited_count == 0) begin
      $display("[nearest_point_search_unit] OK");
    end else begin
      $display("[nearest_point_search_unit] ERROR");
    end
    $finish;
  end

endmodule
